// ===== hw/rtl/ptt_pkg.sv =====
// Shared types and constants for the periodic task timer table.
package ptt_pkg;

  localparam int SLOTS       = 16;
  localparam int PERIOD_BITS = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TICK,
    BK_SCAN
  } back_state_t;

  // One classified request as it travels from the front to the back
  typedef struct packed {
    op_t                     op;
    logic                    slot_ok;
    logic [SLOT_W-1:0]       idx;
    logic [PERIOD_BITS-1:0]  per;
  } item_t;

endpackage

// ===== hw/rtl/ptt_queue.sv =====
// Short request queue between the front and the back of the timer table.
module ptt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ptt_pkg::item_t push_item,
  input  logic          pop,
  output ptt_pkg::item_t head,
  output logic          head_valid,
  output logic          full
);

  ptt_pkg::item_t                    entries [ptt_pkg::QUEUE_DEPTH];
  logic [ptt_pkg::QPTR_W-1:0]        wptr;
  logic [ptt_pkg::QPTR_W-1:0]        rptr;
  logic [ptt_pkg::QCNT_W-1:0]        count;
  logic                              do_push;
  logic                              do_pop;

  assign full       = (count == ptt_pkg::QCNT_W'(ptt_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == ptt_pkg::QPTR_W'(ptt_pkg::QUEUE_DEPTH - 1)) ? '0 :
                ptt_pkg::QPTR_W'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == ptt_pkg::QPTR_W'(ptt_pkg::QUEUE_DEPTH - 1)) ? '0 :
                ptt_pkg::QPTR_W'(rptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= ptt_pkg::QCNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= ptt_pkg::QCNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ===== hw/rtl/ptt_front.sv =====
// Front end: takes command requests and classifies them for the queue.
module ptt_front (
  input  logic          start,
  input  logic [1:0]    command,
  input  logic [3:0]    slot,
  input  logic [15:0]   period,
  input  logic          full,
  output logic          busy,
  output logic          push,
  output ptt_pkg::item_t push_item
);

  // Hold off new requests while the queue is full
  assign busy = full;
  assign push = start && !full;

  // Decode the command and range-check the slot index
  always_comb begin
    push_item.op      = ptt_pkg::op_t'(command);
    push_item.slot_ok = (int'(slot) < ptt_pkg::SLOTS);
    push_item.idx     = ptt_pkg::SLOT_W'(slot);
    push_item.per     = ptt_pkg::PERIOD_BITS'(period);
  end

endmodule

// ===== hw/rtl/ptt_back.sv =====
// Back end: executes requests against the slot table, one slot per cycle on sweeps.
module ptt_back (
  input  logic           clk,
  input  logic           rst,
  input  ptt_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           done,
  output logic [1:0]     status,
  output logic [3:0]     ready_slot,
  output logic           ready_valid,
  output logic           one_shot_removed
);

  localparam int SW = ptt_pkg::SLOT_W;
  localparam int CW = ptt_pkg::CNT_W;
  localparam int PW = ptt_pkg::PERIOD_BITS;

  ptt_pkg::back_state_t   state, state_next;
  logic [CW-1:0]          cnt, cnt_next;
  logic                   pv, pv_next;
  logic [SW-1:0]          pidx, pidx_next;
  logic [ptt_pkg::SLOTS-1:0] active, active_next;
  logic [ptt_pkg::SLOTS-1:0] ready, ready_next;
  logic [ptt_pkg::SLOTS-1:0] oneshot, oneshot_next;

  logic [PW-1:0]          cd_mem  [ptt_pkg::SLOTS];
  logic [PW-1:0]          per_mem [ptt_pkg::SLOTS];
  logic [PW-1:0]          cd_rd;
  logic [PW-1:0]          per_rd;
  logic [SW-1:0]          rd_addr;
  logic [SW-1:0]          wr_addr;
  logic                   cd_we;
  logic                   per_we;
  logic [PW-1:0]          cd_wdata;

  logic [PW-1:0]          tick_dec;
  logic                   tick_zero;
  logic                   tick_fire;
  logic [PW-1:0]          tick_cd;
  logic                   cnt_in_range;
  logic [SW-1:0]          cnt_idx;

  logic                   res_strobe, res_strobe_next;
  ptt_pkg::status_t       res_status, res_status_next;
  logic [3:0]             res_slot, res_slot_next;
  logic                   res_valid, res_valid_next;
  logic                   res_removed, res_removed_next;

  assign cnt_in_range = (cnt < CW'(ptt_pkg::SLOTS));
  assign cnt_idx      = cnt[SW-1:0];

  // Count down one slot of the tick sweep
  assign tick_dec  = (cd_rd != '0) ? PW'(cd_rd - 1'b1) : cd_rd;
  assign tick_zero = (tick_dec == '0);
  assign tick_fire = tick_zero && !ready[pidx];
  assign tick_cd   = (tick_fire && (per_rd != '0)) ? per_rd : tick_dec;

  // Next state, table updates and result
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    pv_next          = 1'b0;
    pidx_next        = pidx;
    active_next      = active;
    ready_next       = ready;
    oneshot_next     = oneshot;
    pop              = 1'b0;
    rd_addr          = cnt_idx;
    wr_addr          = head.idx;
    cd_we            = 1'b0;
    per_we           = 1'b0;
    cd_wdata         = head.per;
    res_strobe_next  = 1'b0;
    res_status_next  = ptt_pkg::ST_OK;
    res_slot_next    = '0;
    res_valid_next   = 1'b0;
    res_removed_next = 1'b0;

    unique case (state)
      ptt_pkg::BK_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.op)
            ptt_pkg::OP_TICK: begin
              state_next = ptt_pkg::BK_TICK;
              cnt_next   = '0;
            end
            ptt_pkg::OP_ADD: begin
              res_strobe_next = 1'b1;
              if (head.slot_ok) begin
                if (active[head.idx]) begin
                  res_status_next = ptt_pkg::ST_REJECT;
                end else begin
                  active_next[head.idx]  = 1'b1;
                  ready_next[head.idx]   = 1'b0;
                  oneshot_next[head.idx] = (head.per == '0);
                  cd_we                  = 1'b1;
                  per_we                 = 1'b1;
                end
              end
            end
            ptt_pkg::OP_REMOVE: begin
              res_strobe_next = 1'b1;
              if (head.slot_ok) begin
                active_next[head.idx] = 1'b0;
                ready_next[head.idx]  = 1'b0;
              end
            end
            ptt_pkg::OP_DISPATCH: begin
              state_next = ptt_pkg::BK_SCAN;
              cnt_next   = '0;
            end
          endcase
        end
      end

      ptt_pkg::BK_TICK: begin
        // issue the read for the next slot
        if (cnt_in_range) begin
          rd_addr   = cnt_idx;
          pv_next   = 1'b1;
          pidx_next = cnt_idx;
          cnt_next  = CW'(cnt + 1'b1);
        end
        // write back the slot whose data just came out of memory
        if (pv && active[pidx]) begin
          cd_we    = 1'b1;
          wr_addr  = pidx;
          cd_wdata = tick_cd;
          if (tick_fire) begin
            ready_next[pidx] = 1'b1;
          end
        end
        if (!cnt_in_range && !pv) begin
          res_strobe_next = 1'b1;
          state_next      = ptt_pkg::BK_IDLE;
        end
      end

      ptt_pkg::BK_SCAN: begin
        if (!cnt_in_range) begin
          res_strobe_next = 1'b1;
          res_status_next = ptt_pkg::ST_EMPTY;
          state_next      = ptt_pkg::BK_IDLE;
        end else if (active[cnt_idx] && ready[cnt_idx]) begin
          ready_next[cnt_idx] = 1'b0;
          if (oneshot[cnt_idx]) begin
            active_next[cnt_idx] = 1'b0;
          end
          res_strobe_next  = 1'b1;
          res_slot_next    = 4'(cnt_idx);
          res_valid_next   = 1'b1;
          res_removed_next = oneshot[cnt_idx];
          state_next       = ptt_pkg::BK_IDLE;
        end else begin
          cnt_next = CW'(cnt + 1'b1);
        end
      end

      default: begin
        state_next = ptt_pkg::BK_IDLE;
      end
    endcase
  end

  // Hold the state register and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptt_pkg::BK_IDLE;
      cnt        <= '0;
      pv         <= 1'b0;
      active     <= '0;
      ready      <= '0;
      res_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pv         <= pv_next;
      active     <= active_next;
      ready      <= ready_next;
      res_strobe <= res_strobe_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pidx        <= pidx_next;
    oneshot     <= oneshot_next;
    res_status  <= res_status_next;
    res_slot    <= res_slot_next;
    res_valid   <= res_valid_next;
    res_removed <= res_removed_next;
  end

  // Countdown and period memories with registered reads
  always_ff @(posedge clk) begin
    if (cd_we) begin
      cd_mem[wr_addr] <= cd_wdata;
    end
    if (per_we) begin
      per_mem[wr_addr] <= head.per;
    end
    cd_rd  <= cd_mem[rd_addr];
    per_rd <= per_mem[rd_addr];
  end

  assign done             = res_strobe;
  assign status           = res_status;
  assign ready_slot       = res_slot;
  assign ready_valid      = res_valid;
  assign one_shot_removed = res_removed;

endmodule

// ===== hw/rtl/periodic_task_timer_table.sv =====
// Add and remove answer with a registered result once the back end takes them;
// tick sweeps every slot, one slot per cycle through the countdown memory read
// port; dispatch scans one slot per cycle from slot 0 to the first ready slot.
// One request runs at a time; a 2-entry queue lets start be taken ahead.
// Reset clears all active and ready flags and the queue; the result strobe
// done pulses for one cycle per request and cannot be stalled.
module periodic_task_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [3:0]  slot,
  input  logic [15:0] period,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  ready_slot,
  output logic        ready_valid,
  output logic        one_shot_removed
);

  logic           push;
  ptt_pkg::item_t push_item;
  ptt_pkg::item_t head;
  logic           head_valid;
  logic           full;
  logic           pop;

  // Classify incoming requests
  ptt_front u_front (
    .start     (start),
    .command   (command),
    .slot      (slot),
    .period    (period),
    .full      (full),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  // Buffer requests between front and back
  ptt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  // Execute requests against the slot table
  ptt_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop),
    .done             (done),
    .status           (status),
    .ready_slot       (ready_slot),
    .ready_valid      (ready_valid),
    .one_shot_removed (one_shot_removed)
  );

endmodule

// ===== hw/rtl/ptt_checker.sv =====
// Port-level checks for the periodic task timer table, bound to the top level.
module ptt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic [3:0] ready_slot,
  input logic       ready_valid,
  input logic       one_shot_removed
);

  // Leave reset idle with nothing reported
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("result or busy right after reset");

  // Raise busy only after a new request has come in
  a_busy_needs_request: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy)
    else $error("busy raised without a new request");

  // A dispatched slot always reports ok
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (done && ready_valid) |-> (status == ptt_pkg::ST_OK))
    else $error("dispatched slot with non-ok status");

  // Removal is only reported with a dispatched slot
  a_removed_valid: assert property (@(posedge clk) disable iff (rst)
    (done && one_shot_removed) |-> ready_valid)
    else $error("one-shot removal without dispatched slot");

  // Error results carry no slot information
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ptt_pkg::ST_REJECT || status == ptt_pkg::ST_EMPTY)) |->
    (!ready_valid && !one_shot_removed && ready_slot == 4'd0))
    else $error("error result with slot fields set");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .status           (status),
  .ready_slot       (ready_slot),
  .ready_valid      (ready_valid),
  .one_shot_removed (one_shot_removed)
);

// ===== tb/periodic_task_timer_table_test.sv =====
// Testbench for the periodic task timer table: directed and random commands with a shadow table.
`timescale 1ns / 1ps

module periodic_task_timer_table_test;
  import ptt_pkg::*;

  localparam int QUIET_LIMIT  = 1000;  // cycles with no request or reply before giving up
  localparam int SETTLE       = 30;    // longest command latency plus margin
  localparam int RANDOM_CMDS  = 1730;
  localparam int CALM_FIRST   = 700;   // commands sent without random idles in this window
  localparam int CALM_LAST    = 1000;

  typedef struct {
    op_t                    op;
    logic [SLOT_W-1:0]      slot;
    logic [PERIOD_BITS-1:0] per;
    bit                     drain;  // wait for all replies before sending
  } cmd_t;

  typedef struct {
    status_t           st;
    logic [SLOT_W-1:0] rslot;
    logic              rvalid;
    logic              removed;
  } reply_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             command = OP_TICK;
  logic [3:0]             slot = '0;
  logic [15:0]            period = '0;
  logic                   done;
  logic [1:0]             status;
  logic [3:0]             ready_slot;
  logic                   ready_valid;
  logic                   one_shot_removed;

  // Shadow of the timer table
  bit                     tbl_active [SLOTS];
  logic [PERIOD_BITS-1:0] tbl_period [SLOTS];
  logic [PERIOD_BITS-1:0] tbl_count  [SLOTS];
  bit                     tbl_ready  [SLOTS];

  cmd_t   cmd_q[$];
  reply_t reply_q[$];
  cmd_t   cur_cmd;

  int n_sent = 0;
  int n_done = 0;
  int n_loaded = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int n_ticks = 0, n_adds = 0, n_rejects = 0, n_removes = 0;
  int n_handed = 0, n_oneshot = 0, n_empty = 0;

  periodic_task_timer_table dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .slot             (slot),
    .period           (period),
    .done             (done),
    .status           (status),
    .ready_slot       (ready_slot),
    .ready_valid      (ready_valid),
    .one_shot_removed (one_shot_removed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the shadow table and return the reply it must produce
  function automatic reply_t next_reply(cmd_t c);
    reply_t r;
    int     i;
    bit     found;
    r = '{ST_OK, '0, 1'b0, 1'b0};
    found = 1'b0;
    case (c.op)
      OP_TICK: begin
        n_ticks++;
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_active[i]) begin
            if (tbl_count[i] != 0) tbl_count[i] = tbl_count[i] - 1'b1;
            if (tbl_count[i] == 0 && !tbl_ready[i]) begin
              tbl_ready[i] = 1'b1;
              if (tbl_period[i] != 0) tbl_count[i] = tbl_period[i];
            end
          end
        end
      end
      OP_ADD: begin
        if (tbl_active[c.slot]) begin
          r.st = ST_REJECT;
          n_rejects++;
        end else begin
          tbl_active[c.slot] = 1'b1;
          tbl_period[c.slot] = c.per;
          tbl_count[c.slot]  = c.per;
          tbl_ready[c.slot]  = 1'b0;
          n_adds++;
        end
      end
      OP_REMOVE: begin
        tbl_active[c.slot] = 1'b0;
        tbl_ready[c.slot]  = 1'b0;
        n_removes++;
      end
      default: begin
        // Lowest ready slot wins
        for (i = 0; i < SLOTS; i++) begin
          if (!found && tbl_active[i] && tbl_ready[i]) begin
            found = 1'b1;
            tbl_ready[i] = 1'b0;
            r.rslot  = i[SLOT_W-1:0];
            r.rvalid = 1'b1;
            if (tbl_period[i] == 0) begin
              tbl_active[i] = 1'b0;
              r.removed = 1'b1;
              n_oneshot++;
            end
            n_handed++;
          end
        end
        if (!found) begin
          r.st = ST_EMPTY;
          n_empty++;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [PERIOD_BITS-1:0] rand_period();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return PERIOD_BITS'($urandom_range(4));
    if (pick < 85) return PERIOD_BITS'($urandom_range(30));
    return PERIOD_BITS'($urandom_range(16'hFFFF));
  endfunction

  task automatic add_cmd(op_t op, int s, int p, bit drain);
    cmd_t c;
    c.op    = op;
    c.slot  = s[SLOT_W-1:0];
    c.per   = p[PERIOD_BITS-1:0];
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  // Driver: hold each request until taken, idle at random, drain where marked
  always @(posedge clk) begin
    bit taken;
    bit idle;
    int open;
    if (rst) begin
      start   <= 1'b0;
      command <= OP_TICK;
      slot    <= '0;
      period  <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        reply_q.push_back(next_reply(cur_cmd));
        n_sent <= n_sent + 1;
      end
      if (!start || taken) begin
        open = n_sent + int'(taken) - n_done;
        idle = (n_loaded < CALM_FIRST || n_loaded >= CALM_LAST) &&
               ($urandom_range(99) < 38);
        if (cmd_q.size() != 0 && !idle && !(cmd_q[0].drain && open != 0)) begin
          cur_cmd = cmd_q.pop_front();
          n_loaded++;
          start   <= 1'b1;
          command <= cur_cmd.op;
          slot    <= cur_cmd.slot;
          period  <= cur_cmd.per;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each reply with the oldest prediction
  always @(posedge clk) begin
    reply_t r;
    if (!rst && done) begin
      n_done <= n_done + 1;
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply status=%0d slot=%0d valid=%0b removed=%0b",
                 $time, status, ready_slot, ready_valid, one_shot_removed);
        errors++;
      end else begin
        r = reply_q.pop_front();
        if (status !== r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, r.st, status);
          errors++;
        end
        if (ready_slot !== r.rslot) begin
          $display("%0t: ready_slot expected %0d actual %0d", $time, r.rslot, ready_slot);
          errors++;
        end
        if (ready_valid !== r.rvalid) begin
          $display("%0t: ready_valid expected %0b actual %0b", $time, r.rvalid, ready_valid);
          errors++;
        end
        if (one_shot_removed !== r.removed) begin
          $display("%0t: one_shot_removed expected %0b actual %0b",
                   $time, r.removed, one_shot_removed);
          errors++;
        end
      end
    end
  end

  // Watchdog: stop if neither requests nor replies move for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d replies outstanding", $time, n_sent - n_done);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k;
    int pick;
    // Directed: empty dispatch, one-shot, period one, extremes, reject, re-add
    add_cmd(OP_DISPATCH, 0, 0, 0);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_ADD, 0, 0, 0);
    add_cmd(OP_ADD, 0, 5, 0);
    add_cmd(OP_ADD, 15, 16'hFFFF, 0);
    add_cmd(OP_ADD, 5, 1, 0);
    add_cmd(OP_ADD, 10, 16'h5555, 0);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_DISPATCH, 0, 0, 0);
    add_cmd(OP_DISPATCH, 0, 0, 0);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_REMOVE, 7, 0, 0);
    add_cmd(OP_DISPATCH, 0, 0, 0);
    add_cmd(OP_REMOVE, 5, 0, 0);
    add_cmd(OP_DISPATCH, 0, 0, 0);
    add_cmd(OP_REMOVE, 15, 0, 0);
    add_cmd(OP_ADD, 15, 2, 0);
    add_cmd(OP_ADD, 3, 0, 0);
    add_cmd(OP_TICK, 0, 0, 1);
    add_cmd(OP_TICK, 0, 0, 0);
    add_cmd(OP_DISPATCH, 0, 0, 0);
    add_cmd(OP_DISPATCH, 0, 0, 0);
    add_cmd(OP_REMOVE, 10, 0, 0);
    add_cmd(OP_DISPATCH, 0, 0, 1);

    // Random: tick-heavy mix so slots come due and get dispatched
    for (k = 0; k < RANDOM_CMDS; k++) begin
      pick = $urandom_range(99);
      if (pick < 40)
        add_cmd(OP_TICK, $urandom_range(15), $urandom_range(16'hFFFF), k % 200 == 199);
      else if (pick < 62)
        add_cmd(OP_ADD, $urandom_range(15), rand_period(), 0);
      else if (pick < 75)
        add_cmd(OP_REMOVE, $urandom_range(15), $urandom_range(16'hFFFF), 0);
      else
        add_cmd(OP_DISPATCH, $urandom_range(15), $urandom_range(16'hFFFF), 0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go out and every reply to come back
    @(negedge clk);
    while (!(cmd_q.size() == 0 && !start && n_sent == n_done)) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    if (reply_q.size() != 0) begin
      $display("%0t: %0d predicted replies never arrived", $time, reply_q.size());
      errors++;
    end
    $display("Sent %0d commands: %0d ticks, %0d adds, %0d rejected adds, %0d removes.",
             n_sent, n_ticks, n_adds, n_rejects, n_removes);
    $display("Dispatch handed out %0d slots (%0d one-shot removed), found none %0d times.",
             n_handed, n_oneshot, n_empty);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== periodic_task_timer_table.f =====
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_queue.sv
hw/rtl/ptt_front.sv
hw/rtl/ptt_back.sv
hw/rtl/periodic_task_timer_table.sv
hw/rtl/ptt_checker.sv
tb/periodic_task_timer_table_test.sv
